/* hw/rtl/srf_bt_pkg.sv */
// shared types, constants and helper functions for the sample ring fifo block
// no dependencies; imported by every module of the block but the ram
`default_nettype none

package srf_bt_pkg;

  localparam int DEPTH  = 64;                 // ring slots in the sample store
  localparam int AW     = $clog2(DEPTH);      // ring index width
  localparam int CW     = 7;                  // capacity register and count width
  localparam int FW     = 6;                  // frames field width
  localparam int SW     = 16;                 // sample width
  localparam int QDEPTH = 2;                  // command queue entries
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int PAW    = 3;                  // apb address width
  localparam int PDW    = 32;                 // apb data width

  localparam logic [CW-1:0] CAP_MIN   = CW'(2);
  localparam logic [CW-1:0] CAP_MAX   = CW'(DEPTH);
  localparam logic [CW-1:0] CAP_RESET = CW'(64);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;       // paddr[2] selects the register

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_PUSH_REJECT = 2'd1,
    ST_POP_REJECT  = 2'd2
  } status_t;

  typedef struct packed {
    logic                 operation;
    logic [FW-1:0]        frames;
    logic signed [SW-1:0] sample;
    logic                 block_end;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic signed [SW-1:0] sample_out;
    logic                 sample_valid;
    logic                 last;
  } out_item_t;

  // work handed from the front to the back
  typedef struct packed {
    logic          is_stream;
    status_t       status;
    logic [AW-1:0] addr;
    logic [FW-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [SW-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
  } ram_rd_t;

  function automatic logic [CW-1:0] eff_cap(input logic [CW-1:0] c);
    logic [CW-1:0] r;
    r = c;
    if (c < CAP_MIN) r = CAP_MIN;
    if (c > CAP_MAX) r = CAP_MAX;
    return r;
  endfunction

  // samples from one ring index up to another
  function automatic logic [CW-1:0] fill_between(input logic [AW-1:0] from,
                                                 input logic [AW-1:0] to,
                                                 input logic [CW-1:0] cap);
    logic [CW-1:0] f;
    logic [CW-1:0] t;
    f = CW'(from);
    t = CW'(to);
    if (t >= f) return t - f;
    return cap - f + t;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/srf_bt_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module srf_bt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srf_bt_cmd_queue.sv */
// short command queue between the front and the back
// depends on srf_bt_pkg
`default_nettype none

module srf_bt_cmd_queue
  import srf_bt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t           entry [QDEPTH];
  logic [QPW-1:0] wptr;
  logic [QPW-1:0] rptr;
  logic [QCW-1:0] count;

  logic do_push;
  logic do_pop;

  assign full       = (count == QCW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entry[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + QCW'(do_push) - QCW'(do_pop);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srf_bt_front.sv */
// front: capacity register, push staging and commit, pop admission
// depends on srf_bt_pkg
`default_nettype none

module srf_bt_front
  import srf_bt_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [PAW-1:0] paddr,
  input  wire logic [PDW-1:0] pwdata,
  output logic      [PDW-1:0] prdata,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire in_item_t       item,
  input  wire logic           back_idle,
  input  wire logic           q_full,
  output logic                q_push,
  output cmd_t                q_cmd,
  output ram_wr_t             ram_wr,
  output logic      [CW-1:0] cap
);

  logic [CW-1:0] capacity;
  logic [AW-1:0] write_index, write_index_next;
  logic [AW-1:0] read_index, read_index_next;
  logic [AW-1:0] staging_index, staging_index_next;
  logic          in_block, in_block_next;
  logic          block_accepted, block_accepted_next;

  logic          cfg_write;
  logic          accept;
  logic [CW-1:0] avail;
  logic [CW-1:0] free_slots;
  logic [CW-1:0] frames_w;
  logic [AW-1:0] stg;
  logic          acc;
  logic [CW-1:0] staged;
  logic          store;
  logic [CW-1:0] stg_inc;
  logic [AW-1:0] stg_after;
  logic [CW-1:0] rd_sum;

  assign cfg_write = psel && penable && pwrite;
  assign prdata    = PDW'(capacity);

  always_comb begin
    cap        = eff_cap(capacity);
    avail      = fill_between(read_index, write_index, cap);
    free_slots = (avail + CW'(1) >= cap) ? '0 : cap - avail - CW'(1);
    frames_w   = CW'(item.frames);
    stg        = in_block ? staging_index : write_index;
    acc        = in_block ? block_accepted : ((frames_w < cap) && (free_slots >= frames_w));
    staged     = fill_between(write_index, stg, cap);
    store      = acc && (staged < frames_w) && (staged < free_slots);
    stg_inc    = CW'(stg) + CW'(1);
    stg_after  = store ? ((stg_inc == cap) ? '0 : stg_inc[AW-1:0]) : stg;
    rd_sum     = CW'(read_index) + frames_w;

    // a push waits while any command is queued or running: a pop may still read
    // slots that the push would overwrite
    item_ready = !q_full && ((item.operation == OP_POP) || back_idle);
    accept     = item_valid && item_ready;

    write_index_next    = write_index;
    read_index_next     = read_index;
    staging_index_next  = staging_index;
    in_block_next       = in_block;
    block_accepted_next = block_accepted;
    q_push              = 1'b0;
    q_cmd               = '{is_stream: 1'b0, status: ST_OK, addr: read_index,
                            count: item.frames};
    ram_wr              = '{en: 1'b0, addr: stg, data: item.sample};

    if (accept) begin
      if (item.operation == OP_PUSH) begin
        if (!in_block && (item.frames == '0)) begin
          q_push = 1'b1;
        end else begin
          ram_wr.en = store;
          if (item.block_end) begin
            q_push              = 1'b1;
            in_block_next       = 1'b0;
            block_accepted_next = 1'b0;
            if (acc) begin
              write_index_next   = stg_after;
              staging_index_next = stg_after;
            end else begin
              q_cmd.status       = ST_PUSH_REJECT;
              staging_index_next = write_index;
            end
          end else begin
            in_block_next       = 1'b1;
            staging_index_next  = stg_after;
            block_accepted_next = acc;
          end
        end
      end else begin
        q_push = 1'b1;
        if (item.frames == '0) begin
          q_cmd.status = ST_OK;
        end else if (avail < frames_w) begin
          q_cmd.status = ST_POP_REJECT;
        end else begin
          q_cmd.is_stream = 1'b1;
          read_index_next = (rd_sum >= cap) ? AW'(rd_sum - cap) : rd_sum[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= CAP_RESET;
      write_index    <= '0;
      read_index     <= '0;
      staging_index  <= '0;
      in_block       <= 1'b0;
      block_accepted <= 1'b0;
    end else if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
      capacity       <= pwdata[CW-1:0];
      write_index    <= '0;
      read_index     <= '0;
      staging_index  <= '0;
      in_block       <= 1'b0;
      block_accepted <= 1'b0;
    end else begin
      write_index    <= write_index_next;
      read_index     <= read_index_next;
      staging_index  <= staging_index_next;
      in_block       <= in_block_next;
      block_accepted <= block_accepted_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srf_bt_back.sv */
// back: runs queued commands, reads the sample store, drives the result channel
// depends on srf_bt_pkg
`default_nettype none

module srf_bt_back
  import srf_bt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [CW-1:0]      cap,
  input  wire logic               head_valid,
  input  wire cmd_t               head_cmd,
  output logic                    q_pop,
  output logic                    idle,
  output ram_rd_t                 ram_rd,
  input  wire logic [SW-1:0]      ram_rdata,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output out_item_t               result
);

  logic          busy;
  cmd_t          cur;
  logic          s1_valid;
  logic          s1_sample;
  status_t       s1_status;
  logic          s1_last;

  logic          s1_adv;
  logic          issue;
  logic          cur_last;
  logic [CW-1:0] addr_inc;

  assign idle     = !busy;
  assign q_pop    = !busy && head_valid;
  assign s1_adv   = s1_valid && (!result_valid || result_ready);
  assign issue    = busy && (!s1_valid || s1_adv);
  assign cur_last = !cur.is_stream || (cur.count == FW'(1));
  assign addr_inc = CW'(cur.addr) + CW'(1);
  assign ram_rd   = '{en: issue && cur.is_stream, addr: cur.addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (issue && cur_last) begin
        busy <= 1'b0;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head_cmd;
    end else if (issue) begin
      cur.addr  <= (addr_inc == cap) ? '0 : addr_inc[AW-1:0];
      cur.count <= cur.count - FW'(1);
    end
    if (issue) begin
      s1_sample <= cur.is_stream;
      s1_status <= cur.status;
      s1_last   <= cur_last;
    end
    if (s1_adv) begin
      result.status       <= s1_status;
      result.sample_out   <= s1_sample ? ram_rdata : '0;
      result.sample_valid <= s1_sample;
      result.last         <= s1_last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sample_ring_fifo_block_transfer_core.sv */
// top level of the sample ring fifo with all-or-nothing block transfers
// depends on srf_bt_pkg, srf_bt_front, srf_bt_cmd_queue, srf_bt_back, srf_bt_ram
`default_nettype none

// Ring fifo of signed 16-bit samples, one slot always kept empty. A push block
// arrives one sample per beat; its first beat decides whether the whole block
// fits, the block_end beat commits it and returns one status beat. A pop beat
// returns one status beat on failure or zero frames, otherwise a stream of
// samples with last on the final one. Flow: push beats are taken one per
// cycle while no command is queued or running in the back, so a push waits
// for any pop ahead of it to issue all its reads and for the previous block's
// status beat to issue. A pop beat is taken one per cycle while the two-entry
// command queue has room. A queued command is first loaded into the back,
// then a pop stream of n samples issues one store read per cycle while the
// result side does not stall, each sample passing through the store read
// register and the output register. Push beats are held off this way because
// pops and pushes share ring slots of the single store. Writing the capacity
// register (APB, byte address 0) empties the fifo and closes any open block;
// the effective capacity is clamped to 2..64.
// No clearing pass after reset: the store needs none.

module sample_ring_fifo_block_transfer_core
  import srf_bt_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  // configuration
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [PAW-1:0] paddr,
  input  wire logic [PDW-1:0] pwdata,
  output logic      [PDW-1:0] prdata,
  output logic                pready,
  // input beats
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire in_item_t       item,
  // result beats
  output logic                result_valid,
  input  wire logic           result_ready,
  output out_item_t           result
);

  logic          q_push;
  cmd_t          q_cmd;
  logic          q_full;
  logic          q_pop;
  logic          head_valid;
  cmd_t          head_cmd;
  logic          back_free;
  logic          back_idle;
  logic [CW-1:0] cap;
  ram_wr_t       ram_wr;
  ram_rd_t       ram_rd;
  logic [SW-1:0] ram_rdata;

  assign pready = 1'b1;

  // back is idle only once no command is queued or running
  assign back_idle = back_free && !head_valid;

  srf_bt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .back_idle  (back_idle),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .ram_wr     (ram_wr),
    .cap        (cap)
  );

  // decouples admission from streaming
  srf_bt_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  srf_bt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cap          (cap),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .q_pop        (q_pop),
    .idle         (back_free),
    .ram_rd       (ram_rd),
    .ram_rdata    (ram_rdata),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // sample store, written by the front and read by the back
  srf_bt_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_rd.en),
    .raddr (ram_rd.addr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_sample_ring_fifo_block_transfer_core.sv */
// self-checking testbench for the sample ring fifo with block transfers
// depends on srf_bt_pkg and sample_ring_fifo_block_transfer_core; reads no files
// keeps its own copy of the ring and indices, and checks every result beat against it
`default_nettype none

module tb_sample_ring_fifo_block_transfer_core;
  import srf_bt_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;   // far above the slowest legal run
  localparam int LONG_HOLD   = 300;         // long receiver hold-off, in cycles
  localparam int QUIET       = 16;          // idle cycles before a register write
  localparam int MAX_REPORTS = 40;
  localparam logic [PAW-1:0] CAP_ADDR = PAW'({REG_CAPACITY, 2'b00});

  // ---------------------------------------------------------------------------
  // block ports; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic           clk     = 1'b0;
  logic           rst     = 1'b1;
  logic           psel    = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite  = 1'b0;
  logic [PAW-1:0] paddr   = '0;
  logic [PDW-1:0] pwdata  = '0;
  logic [PDW-1:0] prdata;
  logic           pready;
  logic           item_valid = 1'b0;
  logic           item_ready;
  in_item_t       item       = '0;
  logic           result_valid;
  logic           result_ready;
  out_item_t      result;

  sample_ring_fifo_block_transfer_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the fifo: committed region is rd_ptr..wr_ptr, an open push
  // block stages its samples from wr_ptr up to stage_ptr
  // ---------------------------------------------------------------------------
  logic [CW-1:0]        cap_reg   = CAP_RESET;
  logic signed [SW-1:0] ring_copy [DEPTH];
  int unsigned          wr_ptr    = 0;
  int unsigned          rd_ptr    = 0;
  int unsigned          stage_ptr = 0;
  bit                   blk_open  = 1'b0;   // a push block has started
  bit                   blk_taken = 1'b0;   // its first beat found room for it
  out_item_t            owed_beats [$];     // result beats the block still owes

  int  errors     = 0;
  int  beats_in   = 0;
  int  beats_out  = 0;
  int  cap_writes = 0;
  int  cycles     = 0;
  bit  src_jitter  = 1'b1;
  bit  sink_jitter = 1'b1;
  bit  long_hold_req = 1'b0;

  // out-of-range capacity settings fold into 2..DEPTH
  function automatic int unsigned live_cap();
    int unsigned c;
    c = cap_reg;
    if (c < CAP_MIN) c = CAP_MIN;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int unsigned ring_span(input int unsigned from, input int unsigned to,
                                            input int unsigned cap);
    if (to >= from) return to - from;
    return cap - from + to;
  endfunction

  // one slot always stays empty
  function automatic int unsigned free_room(input int unsigned cap);
    int unsigned fill;
    fill = ring_span(rd_ptr, wr_ptr, cap);
    if (fill + 1 >= cap) return 0;
    return cap - fill - 1;
  endfunction

  function automatic void owe(input status_t st, input logic signed [SW-1:0] smp,
                              input bit vld, input bit lst);
    out_item_t b;
    b = '{status: st, sample_out: smp, sample_valid: vld, last: lst};
    owed_beats.push_back(b);
  endfunction

  // a capacity write empties the fifo and forgets any open block
  function automatic void reset_fifo_copy(input logic [CW-1:0] value);
    cap_reg   = value;
    wr_ptr    = 0;
    rd_ptr    = 0;
    stage_ptr = 0;
    blk_open  = 1'b0;
    blk_taken = 1'b0;
  endfunction

  // advance the shadow fifo by one accepted input beat, queueing what it owes
  function automatic void apply_fifo_item(input in_item_t it);
    int unsigned cap, n, staged;
    cap = live_cap();
    n   = it.frames;
    if (it.operation == OP_PUSH) begin
      if (!blk_open) begin
        // zero frames with no block open: done at once, block_end ignored
        if (n == 0) begin
          owe(ST_OK, '0, 1'b0, 1'b1);
          return;
        end
        blk_open  = 1'b1;
        stage_ptr = wr_ptr;
        blk_taken = (n < cap) && (free_room(cap) >= n);
      end
      // excess samples, or any sample of a dropped block, go nowhere
      staged = ring_span(wr_ptr, stage_ptr, cap);
      if (blk_taken && staged < n && staged < free_room(cap)) begin
        ring_copy[stage_ptr] = it.sample;
        stage_ptr = (stage_ptr + 1) % cap;
      end
      if (!it.block_end) return;
      blk_open = 1'b0;
      if (blk_taken) begin
        wr_ptr = stage_ptr;     // short blocks commit whatever was staged
        owe(ST_OK, '0, 1'b0, 1'b1);
      end else begin
        stage_ptr = wr_ptr;
        owe(ST_PUSH_REJECT, '0, 1'b0, 1'b1);
      end
      blk_taken = 1'b0;
      return;
    end
    // pops see committed data only, never the staged part of an open block
    if (n == 0) begin
      owe(ST_OK, '0, 1'b0, 1'b1);
    end else if (ring_span(rd_ptr, wr_ptr, cap) < n) begin
      owe(ST_POP_REJECT, '0, 1'b0, 1'b1);
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        owe(ST_OK, ring_copy[rd_ptr], 1'b1, k == n - 1);
        rd_ptr = (rd_ptr + 1) % cap;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  function automatic void note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    else if (errors == MAX_REPORTS + 1) $display("%0t: further mismatches not shown", $time);
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) note_error($sformatf("%s expected %0d actual %0d", name, want, got));
  endfunction

  function automatic void check_beat(input out_item_t got);
    out_item_t want;
    if (owed_beats.size() == 0) begin
      note_error($sformatf("result beat with nothing owed: status %0d sample %0d",
                           got.status, got.sample_out));
      return;
    end
    want = owed_beats.pop_front();
    check_field("status", want.status, got.status);
    check_field("sample_out", want.sample_out, got.sample_out);
    check_field("sample_valid", want.sample_valid, got.sample_valid);
    check_field("last", want.last, got.last);
  endfunction

  // both handshakes sampled at the rising edge; input first so a beat's own
  // expectations are queued before any of its results could be checked
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) begin
        beats_in++;
        apply_fifo_item(item);
      end
      if (result_valid && result_ready) begin
        beats_out++;
        check_beat(result);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d result beats still owed", owed_beats.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // idling: mostly short gaps, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int stall_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_ready = 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        result_ready  = 1'b0;
      end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
        hold_left    = stall_len() - 1;
        result_ready = 1'b0;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers; all of them enter and leave at a falling edge
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_item(input logic op, input int unsigned frames,
                                       input int smp, input bit fin);
    in_item_t r;
    r.operation = op;
    r.frames    = FW'(frames);
    r.sample    = SW'(smp);
    r.block_end = fin;
    return r;
  endfunction

  // offer one beat and hold it until taken; valid stays high unless a gap follows
  task automatic send_beat(input in_item_t it);
    int gap;
    gap = (src_jitter && $urandom_range(0, 2) == 0) ? stall_len() : 0;
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       = it;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic push_samples(input int unsigned frames, input int unsigned count,
                              input bit close);
    for (int unsigned i = 0; i < count; i++)
      send_beat(mk_item(OP_PUSH, frames, $urandom, close && (i == count - 1)));
  endtask

  // sample and block_end carry noise on a pop
  task automatic pop_frames(input int unsigned n);
    send_beat(mk_item(OP_POP, n, $urandom, 1'($urandom_range(0, 1))));
  endtask

  // sender pauses until every owed beat is back, then lets the block go quiet
  task automatic settle();
    item_valid = 1'b0;
    while (owed_beats.size() != 0) @(negedge clk);
    repeat (QUIET) @(negedge clk);
  endtask

  // write then read back; upper data bits carry noise the register must drop
  task automatic write_capacity(input logic [CW-1:0] value);
    settle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CAP_ADDR;
    pwdata  = $urandom;
    pwdata[CW-1:0] = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    reset_fifo_copy(value);
    cap_writes++;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    check_field("capacity read back", value, prdata[CW-1:0]);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero-length push with either block_end, zero-length pop, pop of an empty fifo
  task automatic test_zero_length();
    send_beat(mk_item(OP_PUSH, 0, 32767, 1'b0));
    send_beat(mk_item(OP_PUSH, 0, -32768, 1'b1));
    pop_frames(0);
    pop_frames(5);
    settle();
  endtask

  // sample extremes through the ring at reset capacity
  task automatic test_sample_extremes();
    send_beat(mk_item(OP_PUSH, 4, -32768, 1'b0));
    send_beat(mk_item(OP_PUSH, 4, 32767, 1'b0));
    send_beat(mk_item(OP_PUSH, 4, 0, 1'b0));
    send_beat(mk_item(OP_PUSH, 4, -1, 1'b1));
    pop_frames(4);
    settle();
  endtask

  // capacity 4: usable depth 3
  task automatic test_space_rejects();
    write_capacity(7'd4);
    push_samples(4, 2, 1'b1);     // block as long as the capacity: dropped
    push_samples(3, 3, 1'b1);     // fills the usable depth
    push_samples(1, 1, 1'b1);     // no room left
    push_samples(63, 1, 1'b1);    // longest block, far too long
    pop_frames(4);                // more than stored
    pop_frames(3);
    settle();
  endtask

  task automatic test_block_shapes();
    push_samples(3, 1, 1'b1);     // short block commits its one sample
    push_samples(2, 3, 1'b1);     // third sample is excess
    pop_frames(2);
    push_samples(2, 1, 1'b0);     // leave an accepted block open
    pop_frames(1);                // must not see the staged sample
    push_samples(2, 1, 1'b1);
    pop_frames(2);
    settle();
  endtask

  // register write with a block still open: block is forgotten
  task automatic test_config_mid_block();
    push_samples(2, 1, 1'b0);
    write_capacity(7'd0);         // clamps to 2, usable depth 1
    push_samples(1, 1, 1'b1);
    pop_frames(1);
    pop_frames(1);
    settle();
  endtask

  // longest blocks, twice so the second one wraps the ring
  task automatic test_full_depth();
    write_capacity(7'd64);
    repeat (2) begin
      push_samples(63, 63, 1'b1);
      pop_frames(63);
    end
    settle();
  endtask

  // receiver holds off while pops pile up behind it and pushes wait their turn
  task automatic test_backpressure();
    push_samples(20, 20, 1'b1);
    long_hold_req = 1'b1;
    repeat (8) pop_frames(2);
    push_samples(4, 4, 1'b1);
    pop_frames(3);
    settle();
  endtask

  task automatic random_sequence();
    int unsigned cap, fill, n, k, pick;
    logic [31:0] raw;
    cap  = live_cap();
    fill = ring_span(rd_ptr, wr_ptr, cap);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // well-formed block, mostly sized to fit
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63)
                                      : $urandom_range(1, (cap > 9) ? 8 : cap - 1);
      push_samples(n, n, 1'b1);
    end else if (pick < 72) begin
      n = (fill > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(1, fill)
                                                  : $urandom_range(0, 63);
      pop_frames(n);
    end else if (pick < 84) begin
      // broken block: wandering frames, wrong sample count, early ends
      n = $urandom_range(1, 12);
      k = $urandom_range(1, n + 3);
      for (int unsigned i = 0; i < k; i++)
        send_beat(mk_item(OP_PUSH, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : n,
                          $urandom, (i == k - 1) || ($urandom_range(0, 9) == 0)));
    end else if (pick < 90) begin
      send_beat(mk_item(1'($urandom_range(0, 1)), 0, $urandom, 1'($urandom_range(0, 1))));
    end else begin
      raw = $urandom;
      send_beat(in_item_t'(raw[$bits(in_item_t)-1:0]));
    end
  endtask

  // one phase per capacity setting, extremes and clamped values among them
  task automatic test_random_traffic();
    logic [CW-1:0] plan [10];
    int target;
    plan = '{7'd64, 7'd3, 7'd127, 7'd2, 7'd1, 7'd33, 7'd63, 7'd100, 7'd0, 7'd64};
    plan[9] = CW'($urandom_range(2, 64));
    foreach (plan[p]) begin
      write_capacity(plan[p]);
      src_jitter  = (p != 3) && ($urandom_range(0, 3) != 0);
      sink_jitter = (p != 3) && ($urandom_range(0, 3) != 0);
      target = beats_in + 30;
      while (beats_in < target) random_sequence();
    end
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_zero_length();
    test_sample_extremes();
    test_space_rejects();
    test_block_shapes();
    test_config_mid_block();
    test_full_depth();
    test_backpressure();
    test_random_traffic();
    settle();
    $display("covered %0d input beats and %0d result beats across %0d capacity writes",
             beats_in, beats_out, cap_writes);
    $display("zero-length, rejected, short, excess, open and full-depth blocks, with stalls");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
